/* hdl/lqm_pkg.sv */
// ----------------------------------------------------------------------------
// lqm_pkg
// Types, operation codes and status codes of the linked queue manager.
// ----------------------------------------------------------------------------
`default_nettype none

package lqm_pkg;

   localparam int SLOT_W     = 6;
   localparam int SLOT_COUNT = 1 << SLOT_W;
   localparam int OBJ_W      = 32;
   localparam int LEN_W      = 7;
   localparam int OP_W       = 3;
   localparam int STATUS_W   = 3;

   typedef logic [SLOT_W-1:0]   slot_type;
   typedef logic [OBJ_W-1:0]    obj_type;
   typedef logic [LEN_W-1:0]    len_type;
   typedef logic [OP_W-1:0]     op_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam op_type OP_PUSH   = 3'd0;
   localparam op_type OP_POP    = 3'd1;
   localparam op_type OP_REMOVE = 3'd2;
   localparam op_type OP_QUERY  = 3'd3;
   localparam op_type OP_FIRST  = 3'd4;
   localparam op_type OP_STEP   = 3'd5;

   localparam status_type STAT_OK         = 3'd0;
   localparam status_type STAT_EMPTY      = 3'd1;
   localparam status_type STAT_ALREADY    = 3'd2;
   localparam status_type STAT_NOT_MEMBER = 3'd3;
   localparam status_type STAT_END        = 3'd4;

endpackage

`default_nettype wire

/* hdl/lqm_req_if.sv */
// ----------------------------------------------------------------------------
// lqm_req_if
// Request channel of the linked queue manager: valid/ready and one operation.
// ----------------------------------------------------------------------------
`default_nettype none

interface lqm_req_if
   import lqm_pkg::*;
();
   logic     valid;
   logic     ready;
   op_type   opcode;
   slot_type slot_index;
   obj_type  object_value;

   modport source (output valid, output opcode, output slot_index,
                   output object_value, input ready);
   modport sink   (input valid, input opcode, input slot_index,
                   input object_value, output ready);
endinterface

`default_nettype wire

/* hdl/lqm_rsp_if.sv */
// ----------------------------------------------------------------------------
// lqm_rsp_if
// Response channel of the linked queue manager: valid/ready and one result.
// ----------------------------------------------------------------------------
`default_nettype none

interface lqm_rsp_if
   import lqm_pkg::*;
();
   logic       valid;
   logic       ready;
   status_type status;
   slot_type   result_slot;
   obj_type    result_object;
   logic       is_member;
   len_type    queue_length;

   modport source (output valid, output status, output result_slot,
                   output result_object, output is_member, output queue_length,
                   input ready);
   modport sink   (input valid, input status, input result_slot,
                   input result_object, input is_member, input queue_length,
                   output ready);
endinterface

`default_nettype wire

/* hdl/lqm_ram.sv */
// ----------------------------------------------------------------------------
// lqm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lqm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW   = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/linked_queue_manager_core.sv */
// ----------------------------------------------------------------------------
// linked_queue_manager_core
// FIFO queue threaded through a pool of 64 slots with prev/next links.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one operation per beat: push, pop, remove, membership
//   query, first, or step toward the tail. rsp_ch returns exactly one result
//   beat per request, in order, with status, slot, object word, membership of
//   the given slot before the operation and the queue length after it.
//   The block works on one request at a time. req_ch.ready is high only while
//   the sequencer is idle; a request runs from accept to the next accept in
//   steps set by the single registered read port of the link and object
//   memories: read, relink, post the result, and for step a second object
//   read at the successor slot before the post.
//   The result passes through the result and output registers onto rsp_ch.
//   A waiting result sits in the output register; a new request is still
//   taken, but its result is held back until the receiver takes the old one.
//   Synchronous reset empties the queue: all membership flags, head, tail and
//   length clear at once, no clearing pass. Link and object memories are not
//   cleared; the queue never uses an entry before writing it.
// ----------------------------------------------------------------------------
`default_nettype none

module linked_queue_manager_core
   import lqm_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   lqm_req_if.sink   req_ch,
   lqm_rsp_if.source rsp_ch
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RD   = 3'd1;
   localparam logic [2:0] ST_LINK = 3'd2;
   localparam logic [2:0] ST_OBJ  = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;

   logic [2:0] state_ff, state_in;

   op_type   op_ff, op_in;
   slot_type slot_ff, slot_in;
   obj_type  obj_ff, obj_in;
   logic     was_ff, was_in;

   slot_type head_ff, head_in;
   slot_type tail_ff, tail_in;
   len_type  len_ff, len_in;
   logic [SLOT_COUNT-1:0] flag_ff, flag_in;

   status_type res_status_ff, res_status_in;
   slot_type   res_slot_ff, res_slot_in;
   obj_type    res_obj_ff, res_obj_in;

   logic       rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff, rsp_status_in;
   slot_type   rsp_slot_ff, rsp_slot_in;
   obj_type    rsp_obj_ff, rsp_obj_in;
   logic       rsp_member_ff, rsp_member_in;
   len_type    rsp_len_ff, rsp_len_in;

   // memory ports
   logic     link_rd_en;
   slot_type link_rd_addr;
   slot_type prev_rd, next_rd;
   logic     prev_we, next_we;
   slot_type prev_wa, prev_wd, next_wa, next_wd;
   logic     obj_rd_en;
   slot_type obj_rd_addr;
   obj_type  obj_rd;
   logic     obj_we;

   logic accept;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;

   lqm_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_COUNT)) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_we),
      .wr_addr (prev_wa),
      .wr_data (prev_wd),
      .rd_en   (link_rd_en),
      .rd_addr (link_rd_addr),
      .rd_data (prev_rd)
   );

   lqm_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_COUNT)) u_next_ram (
      .clock   (clock),
      .wr_en   (next_we),
      .wr_addr (next_wa),
      .wr_data (next_wd),
      .rd_en   (link_rd_en),
      .rd_addr (link_rd_addr),
      .rd_data (next_rd)
   );

   lqm_ram #(.WIDTH(OBJ_W), .DEPTH(SLOT_COUNT)) u_obj_ram (
      .clock   (clock),
      .wr_en   (obj_we),
      .wr_addr (slot_ff),
      .wr_data (obj_ff),
      .rd_en   (obj_rd_en),
      .rd_addr (obj_rd_addr),
      .rd_data (obj_rd)
   );

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      slot_in       = slot_ff;
      obj_in        = obj_ff;
      was_in        = was_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      len_in        = len_ff;
      flag_in       = flag_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_obj_in    = res_obj_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_obj_in    = rsp_obj_ff;
      rsp_member_in = rsp_member_ff;
      rsp_len_in    = rsp_len_ff;

      link_rd_en   = 1'b0;
      link_rd_addr = (op_ff inside {OP_POP, OP_FIRST}) ? head_ff : slot_ff;
      obj_rd_en    = 1'b0;
      obj_rd_addr  = link_rd_addr;
      prev_we      = 1'b0;
      prev_wa      = slot_ff;
      prev_wd      = tail_ff;
      next_we      = 1'b0;
      next_wa      = tail_ff;
      next_wd      = slot_ff;
      obj_we       = 1'b0;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = req_ch.opcode;
               slot_in  = req_ch.slot_index;
               obj_in   = req_ch.object_value;
               was_in   = flag_ff[req_ch.slot_index];
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            link_rd_en = 1'b1;
            obj_rd_en  = 1'b1;
            state_in   = ST_LINK;
         end
         ST_LINK: begin
            res_status_in = STAT_OK;
            res_slot_in   = '0;
            res_obj_in    = '0;
            state_in      = ST_FIN;
            case (op_ff)
               OP_PUSH: begin
                  if (was_ff) begin
                     res_status_in = STAT_ALREADY;
                  end else begin
                     obj_we            = 1'b1;
                     flag_in[slot_ff]  = 1'b1;
                     if (len_ff == '0) begin
                        head_in = slot_ff;
                     end else begin
                        next_we = 1'b1;
                        prev_we = 1'b1;
                     end
                     tail_in     = slot_ff;
                     len_in      = len_ff + LEN_W'(1);
                     res_slot_in = slot_ff;
                     res_obj_in  = obj_ff;
                  end
               end
               OP_POP: begin
                  if (len_ff == '0) begin
                     res_status_in = STAT_EMPTY;
                  end else begin
                     flag_in[head_ff] = 1'b0;
                     len_in           = len_ff - LEN_W'(1);
                     // head stays put when the last member leaves
                     if (len_ff != LEN_W'(1)) begin
                        head_in = next_rd;
                     end
                     res_slot_in = head_ff;
                     res_obj_in  = obj_rd;
                  end
               end
               OP_REMOVE: begin
                  if (!was_ff) begin
                     res_status_in = STAT_NOT_MEMBER;
                  end else begin
                     if (slot_ff == head_ff && slot_ff == tail_ff) begin
                        // last member leaves, pointers untouched
                     end else if (slot_ff == head_ff) begin
                        head_in = next_rd;
                     end else if (slot_ff == tail_ff) begin
                        tail_in = prev_rd;
                     end else begin
                        // splice neighbors around the removed slot
                        next_we = 1'b1;
                        next_wa = prev_rd;
                        next_wd = next_rd;
                        prev_we = 1'b1;
                        prev_wa = next_rd;
                        prev_wd = prev_rd;
                     end
                     flag_in[slot_ff] = 1'b0;
                     len_in           = len_ff - LEN_W'(1);
                     res_slot_in      = slot_ff;
                     res_obj_in       = obj_rd;
                  end
               end
               OP_QUERY: begin
                  res_slot_in = slot_ff;
               end
               OP_FIRST: begin
                  if (len_ff == '0) begin
                     res_status_in = STAT_EMPTY;
                  end else begin
                     res_slot_in = head_ff;
                     res_obj_in  = obj_rd;
                  end
               end
               OP_STEP: begin
                  if (!was_ff) begin
                     res_status_in = STAT_NOT_MEMBER;
                  end else if (slot_ff == tail_ff) begin
                     res_status_in = STAT_END;
                  end else begin
                     // second object read at the successor
                     obj_rd_en   = 1'b1;
                     obj_rd_addr = next_rd;
                     res_slot_in = next_rd;
                     state_in    = ST_OBJ;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_OBJ: begin
            res_obj_in = obj_rd;
            state_in   = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_obj_in    = res_obj_ff;
               rsp_member_in = was_ff;
               rsp_len_in    = len_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         len_ff       <= '0;
         flag_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         len_ff       <= len_in;
         flag_ff      <= flag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      slot_ff       <= slot_in;
      obj_ff        <= obj_in;
      was_ff        <= was_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_obj_ff    <= res_obj_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_obj_ff    <= rsp_obj_in;
      rsp_member_ff <= rsp_member_in;
      rsp_len_ff    <= rsp_len_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = rsp_status_ff;
   assign rsp_ch.result_slot   = rsp_slot_ff;
   assign rsp_ch.result_object = rsp_obj_ff;
   assign rsp_ch.is_member     = rsp_member_ff;
   assign rsp_ch.queue_length  = rsp_len_ff;

   // length always matches the number of member flags
   a_len_matches_flags : assert property (@(posedge clock) disable iff (reset)
      $countones(flag_ff) == int'(len_ff))
      else $error("queue length disagrees with membership flags");

   a_len_bounded : assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(SLOT_COUNT))
      else $error("queue length above slot count");

   a_accept_starts_read : assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_RD)
      else $error("accepted request did not start a memory read");

   a_rsp_from_fin : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FIN)
      else $error("response beat raised outside the finish step");

endmodule

`default_nettype wire
